FILE: rtl/qmi_pkg.sv
// Shared types, constants and tables for the quadrature motor interface.
// No dependencies; the top level, the decoder and the testbench import this package.
package qmi_pkg;

    localparam int PWM_BITS_DEF   = 8;
    localparam int COUNT_BITS_DEF = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_SCALE       = 2'd1;

    localparam logic [31:0] REPORT_INTERVAL_RST = 32'd200000;
    localparam logic [15:0] RPM_SCALE_RST       = 16'd12;

    localparam logic [7:0] DUTY_FULL = 8'd255;

    // ASCII command bytes
    localparam logic [7:0] CMD_DIGIT_0 = 8'h30;
    localparam logic [7:0] CMD_DIGIT_9 = 8'h39;
    localparam logic [7:0] CMD_FULL    = 8'h66;
    localparam logic [7:0] CMD_STOP    = 8'h73;
    localparam logic [7:0] CMD_DIR     = 8'h64;

    // {last A, last B, A, B} transition codes
    localparam logic [3:0] TR_UP_0 = 4'b0001;
    localparam logic [3:0] TR_UP_1 = 4'b0111;
    localparam logic [3:0] TR_UP_2 = 4'b1110;
    localparam logic [3:0] TR_UP_3 = 4'b1000;
    localparam logic [3:0] TR_DN_0 = 4'b0010;
    localparam logic [3:0] TR_DN_1 = 4'b1011;
    localparam logic [3:0] TR_DN_2 = 4'b1101;
    localparam logic [3:0] TR_DN_3 = 4'b0100;

    typedef struct packed {
        logic up;
        logic dn;
    } t_qstep;

    // duty = d * 255 / 10, rounded down
    function automatic logic [7:0] digit_duty(input logic [3:0] d);
        logic [7:0] duty;
        unique case (d)
            4'd0:    duty = 8'd0;
            4'd1:    duty = 8'd25;
            4'd2:    duty = 8'd51;
            4'd3:    duty = 8'd76;
            4'd4:    duty = 8'd102;
            4'd5:    duty = 8'd127;
            4'd6:    duty = 8'd153;
            4'd7:    duty = 8'd178;
            4'd8:    duty = 8'd204;
            4'd9:    duty = 8'd229;
            default: duty = 8'd0;
        endcase
        return duty;
    endfunction

endpackage

FILE: rtl/qmi_in_if.sv
// Input channel: one sampled encoder word with an optional command byte.
// Standalone; no package needed.
interface qmi_in_if;
    logic       valid;
    logic       ready;
    logic       enc_a;
    logic       enc_b;
    logic       cmd_valid;
    logic [7:0] cmd_byte;

    modport source (output valid, output enc_a, output enc_b, output cmd_valid,
                    output cmd_byte, input ready);
    modport sink   (input valid, input enc_a, input enc_b, input cmd_valid,
                    input cmd_byte, output ready);
endinterface

FILE: rtl/qmi_out_if.sv
// Output channel: drive line levels and the periodic speed report.
// Standalone; no package needed.
interface qmi_out_if;
    logic               valid;
    logic               ready;
    logic               drive_fwd_line;
    logic               drive_rev_line;
    logic               report_valid;
    logic [31:0]        report_time;
    logic [7:0]         report_duty;
    logic signed [31:0] report_position;
    logic signed [31:0] report_rpm_centi;

    modport source (output valid, output drive_fwd_line, output drive_rev_line,
                    output report_valid, output report_time, output report_duty,
                    output report_position, output report_rpm_centi, input ready);
    modport sink   (input valid, input drive_fwd_line, input drive_rev_line,
                    input report_valid, input report_time, input report_duty,
                    input report_position, input report_rpm_centi, output ready);
endinterface

FILE: rtl/quadrature_motor_interface.sv
// Top level: quadrature decoder, command-driven PWM bridge driver, speed reporter.
// Depends on qmi_pkg, qmi_in_if, qmi_out_if and qmi_quad_dec.
//
//   channel   dir  handshake          word
//   i_in      in   valid/ready        enc_a, enc_b, cmd_valid, cmd_byte
//   o_out     out  valid/ready        drive lines and report fields
//   i_cfg_*   in   write enable only  index, 32-bit data
//
// One word per cycle while o_out is not stalled: input register, one stage of
// logic (decode, delta times rpm_scale, saturate), result register. While
// the result waits, one more word is held in the input register; ready drops
// only when both are full. Reset is synchronous and loads the register
// defaults.
module quadrature_motor_interface #(
    parameter int PWM_BITS   = qmi_pkg::PWM_BITS_DEF,
    parameter int COUNT_BITS = qmi_pkg::COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    qmi_in_if.sink                         i_in,
    qmi_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [qmi_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [qmi_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import qmi_pkg::*;

    localparam int PROD_W = COUNT_BITS + 17;

    // configuration
    logic [31:0] r_interval;
    logic [15:0] r_scale;

    // input register
    logic       r_in_vld;
    logic       r_in_a;
    logic       r_in_b;
    logic       r_in_cmd_vld;
    logic [7:0] r_in_cmd;

    // block state
    logic [1:0]            r_last_ab;
    logic                  r_primed;
    logic [COUNT_BITS-1:0] r_pos;
    logic [COUNT_BITS-1:0] r_win;
    logic [31:0]           r_time;
    logic [31:0]           r_elapsed;
    logic [7:0]            r_duty;
    logic                  r_rev;
    logic [PWM_BITS-1:0]   r_phase;

    // result register
    logic               r_out_vld;
    logic               r_fwd;
    logic               r_revl;
    logic               r_rpt;
    logic [31:0]        r_rpt_time;
    logic [7:0]         r_rpt_duty;
    logic [31:0]        r_rpt_pos;
    logic [31:0]        r_rpt_rpm;

    logic                  adv;
    t_qstep                step;
    logic [COUNT_BITS-1:0] n_pos;
    logic [COUNT_BITS-1:0] n_win;
    logic [7:0]            n_duty;
    logic                  n_rev;
    logic [PWM_BITS+7:0]   duty_wide;
    logic [PWM_BITS-1:0]   thr;
    logic                  lvl;
    logic                  rpt;
    logic signed [PROD_W-1:0] prod_a;
    logic signed [PROD_W-1:0] prod_b;
    logic signed [PROD_W-1:0] prod;
    logic                  fits;
    logic [31:0]           rpm_sat;
    logic [COUNT_BITS+31:0] pos_ext;

    assign adv        = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || adv;

    qmi_quad_dec u_dec (
        .i_primed  (r_primed),
        .i_last_ab (r_last_ab),
        .i_ab      ({r_in_a, r_in_b}),
        .o_step    (step)
    );

    always_comb begin
        n_pos = r_pos;
        n_win = r_win;
        if (step.up) begin
            n_pos = r_pos + COUNT_BITS'(1);
            n_win = r_win + COUNT_BITS'(1);
        end else if (step.dn) begin
            n_pos = r_pos - COUNT_BITS'(1);
            n_win = r_win - COUNT_BITS'(1);
        end
    end

    always_comb begin
        n_duty = r_duty;
        n_rev  = r_rev;
        if (r_in_cmd_vld) begin
            priority if (r_in_cmd >= CMD_DIGIT_0 && r_in_cmd <= CMD_DIGIT_9) begin
                n_duty = digit_duty(4'(r_in_cmd - CMD_DIGIT_0));
            end else if (r_in_cmd == CMD_FULL) begin
                n_duty = DUTY_FULL;
            end else if (r_in_cmd == CMD_STOP) begin
                n_duty = '0;
            end else if (r_in_cmd == CMD_DIR) begin
                n_duty = '0;
                n_rev  = !r_rev;
            end else begin
                // other bytes: hold
                n_duty = r_duty;
            end
        end
    end

    // scale the 8-bit duty to the PWM counter width
    assign duty_wide = {n_duty, {PWM_BITS{1'b0}}};
    assign thr       = duty_wide[PWM_BITS+7:8];

    always_comb begin
        if (n_duty == '0) begin
            lvl = 1'b0;
        end else if (n_duty == DUTY_FULL) begin
            lvl = 1'b1;
        end else begin
            lvl = r_phase < thr;
        end
    end

    assign rpt = r_elapsed >= r_interval;

    assign prod_a  = {{17{n_win[COUNT_BITS-1]}}, n_win};
    assign prod_b  = {{(COUNT_BITS+1){1'b0}}, r_scale};
    assign prod    = prod_a * prod_b;
    assign fits    = (&prod[PROD_W-1:31]) || !(|prod[PROD_W-1:31]);
    assign rpm_sat = fits ? prod[31:0]
                   : (prod[PROD_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    assign pos_ext = {{32{n_pos[COUNT_BITS-1]}}, n_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= REPORT_INTERVAL_RST;
            r_scale    <= RPM_SCALE_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_REPORT_INTERVAL) begin
                r_interval <= i_cfg_data[31:0];
            end else if (i_cfg_idx == CFG_RPM_SCALE) begin
                r_scale <= i_cfg_data[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_a       <= i_in.enc_a;
            r_in_b       <= i_in.enc_b;
            r_in_cmd_vld <= i_in.cmd_valid;
            r_in_cmd     <= i_in.cmd_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_ab <= '0;
            r_primed  <= 1'b0;
            r_pos     <= '0;
            r_win     <= '0;
            r_time    <= '0;
            r_elapsed <= '0;
            r_duty    <= '0;
            r_rev     <= 1'b0;
            r_phase   <= '0;
        end else if (adv) begin
            r_last_ab <= {r_in_a, r_in_b};
            r_primed  <= 1'b1;
            r_pos     <= n_pos;
            // restart the window on a report
            r_win     <= rpt ? '0 : n_win;
            r_elapsed <= rpt ? 32'd1 : r_elapsed + 32'd1;
            r_time    <= r_time + 32'd1;
            r_duty    <= n_duty;
            r_rev     <= n_rev;
            r_phase   <= r_phase + PWM_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fwd      <= n_rev ? 1'b0 : lvl;
            r_revl     <= n_rev ? lvl : 1'b0;
            r_rpt      <= rpt;
            r_rpt_time <= rpt ? r_time : '0;
            r_rpt_duty <= rpt ? n_duty : '0;
            r_rpt_pos  <= rpt ? pos_ext[31:0] : '0;
            r_rpt_rpm  <= rpt ? rpm_sat : '0;
        end
    end

    assign o_out.valid            = r_out_vld;
    assign o_out.drive_fwd_line   = r_fwd;
    assign o_out.drive_rev_line   = r_revl;
    assign o_out.report_valid     = r_rpt;
    assign o_out.report_time      = r_rpt_time;
    assign o_out.report_duty      = r_rpt_duty;
    assign o_out.report_position  = signed'(r_rpt_pos);
    assign o_out.report_rpm_centi = signed'(r_rpt_rpm);

endmodule

FILE: rtl/qmi_quad_dec.sv
// x4 quadrature transition decoder: classifies one A/B sample against the last.
// Depends on qmi_pkg (t_qstep, transition codes).
module qmi_quad_dec (
    input  logic             i_primed,
    input  logic [1:0]       i_last_ab,
    input  logic [1:0]       i_ab,
    output qmi_pkg::t_qstep  o_step
);
    import qmi_pkg::*;

    logic [3:0] tr;

    assign tr = {i_last_ab, i_ab};

    always_comb begin
        o_step = '0;
        if (i_primed) begin
            // single-line changes only; double and no changes hold
            unique case (tr)
                TR_UP_0, TR_UP_1, TR_UP_2, TR_UP_3: o_step.up = 1'b1;
                TR_DN_0, TR_DN_1, TR_DN_2, TR_DN_3: o_step.dn = 1'b1;
                default: o_step = '0;
            endcase
        end
    end

endmodule

FILE: tb/quadrature_motor_interface_test.sv
// Self-checking testbench for quadrature_motor_interface: random valid/ready traffic on both
// channels, results checked in order against a cycle-free model of decoder, PWM and reporter.
// Depends on qmi_pkg, qmi_in_if, qmi_out_if and the RTL top level.
module quadrature_motor_interface_test;
    timeunit 1ns;
    timeprecision 1ps;

    import qmi_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned PHASE_WORDS   = 240;
    localparam longint      SPEED_MAX     = 64'sd2147483647;
    localparam longint      SPEED_MIN     = -64'sd2147483648;
    // encoder levels for the directed part: every ordered pair of {A,B} appears at least once
    localparam logic [39:0] DIRECTED_AB   = {2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3,
                                             2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1,
                                             2'd0, 2'd0, 2'd3, 2'd3};

    typedef struct packed {
        logic       a;
        logic       b;
        logic       cv;
        logic [7:0] cb;
    } sample_word_t;

    typedef struct packed {
        logic        fwd;
        logic        rev;
        logic        rpt;
        logic [31:0] rtime;
        logic [7:0]  duty;
        logic [31:0] pos;
        logic [31:0] rpm;
    } motor_result_t;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    qmi_in_if  in_if ();
    qmi_out_if out_if ();

    quadrature_motor_interface u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // model state and register copies
    logic [1:0]  enc_last        = '0;
    logic        enc_primed      = 1'b0;
    logic [31:0] enc_count       = '0;
    logic [31:0] window_count    = '0;
    logic [31:0] tick_count      = '0;
    logic [31:0] window_time     = '0;
    logic [7:0]  duty            = '0;
    logic        reverse         = 1'b0;
    logic [7:0]  pwm_phase       = '0;
    logic [31:0] report_interval = REPORT_INTERVAL_RST;
    logic [15:0] rpm_scale       = RPM_SCALE_RST;

    sample_word_t  pending_words[$];
    motor_result_t expected_results[$];
    int unsigned   queued_count   = 0;
    int unsigned   checked_count  = 0;
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count    = 0;
    int unsigned   tx_wait        = 0;
    int unsigned   rx_wait        = 0;
    int unsigned   tx_gap_max     = 3;
    int unsigned   rx_gap_max     = 3;
    logic [1:0]    stim_ab        = '0;
    bit            motion_fwd     = 1'b1;

    function automatic motor_result_t motor_step(input sample_word_t w);
        motor_result_t r;
        logic [3:0]    tr;
        logic [31:0]   delta;
        logic          lvl;
        longint        speed;
        int            d;
        r = '0;
        if (!enc_primed) begin
            enc_primed = 1'b1;
        end else begin
            tr = {enc_last, w.a, w.b};
            case (tr)
                TR_UP_0, TR_UP_1, TR_UP_2, TR_UP_3: enc_count = enc_count + 32'd1;
                TR_DN_0, TR_DN_1, TR_DN_2, TR_DN_3: enc_count = enc_count - 32'd1;
                default: ;
            endcase
        end
        enc_last = {w.a, w.b};
        if (w.cv) begin
            if (w.cb >= CMD_DIGIT_0 && w.cb <= CMD_DIGIT_9) begin
                d    = int'(w.cb) - int'(CMD_DIGIT_0);
                duty = 8'((d * int'(DUTY_FULL)) / 10);
            end else if (w.cb == CMD_FULL) begin
                duty = DUTY_FULL;
            end else if (w.cb == CMD_STOP) begin
                duty = '0;
            end else if (w.cb == CMD_DIR) begin
                duty    = '0;
                reverse = !reverse;
            end
        end
        if (duty == 8'd0)
            lvl = 1'b0;
        else if (duty == DUTY_FULL)
            lvl = 1'b1;
        else
            lvl = (pwm_phase < duty);
        r.fwd = reverse ? 1'b0 : lvl;
        r.rev = reverse ? lvl : 1'b0;
        if ((tick_count - window_time) >= report_interval) begin
            delta = enc_count - window_count;
            speed = longint'($signed(delta)) * longint'(rpm_scale);
            if (speed > SPEED_MAX)
                speed = SPEED_MAX;
            if (speed < SPEED_MIN)
                speed = SPEED_MIN;
            window_time  = tick_count;
            window_count = enc_count;
            r.rpt   = 1'b1;
            r.rtime = tick_count;
            r.duty  = duty;
            r.pos   = enc_count;
            r.rpm   = speed[31:0];
        end
        pwm_phase  = pwm_phase + 8'd1;
        tick_count = tick_count + 32'd1;
        return r;
    endfunction

    function automatic string show_result(input motor_result_t r);
        return $sformatf("fwd=%0b rev=%0b rpt=%0b time=%0d duty=%0d pos=%0d rpm=%0d",
                         r.fwd, r.rev, r.rpt, r.rtime, r.duty, $signed(r.pos),
                         $signed(r.rpm));
    endfunction

    // next level pair one quadrature step forward or back
    function automatic logic [1:0] step_ab(input logic [1:0] ab, input bit fwd);
        logic [1:0] idx;
        idx = {ab[1], ab[1] ^ ab[0]};
        idx = fwd ? idx + 2'd1 : idx - 2'd1;
        return {idx[1], idx[1] ^ idx[0]};
    endfunction

    task automatic queue_word(input logic [1:0] ab, input logic cv, input logic [7:0] cb);
        pending_words.push_back('{a: ab[1], b: ab[0], cv: cv, cb: cb});
        stim_ab = ab;
        queued_count++;
    endtask

    function automatic logic [8:0] random_command();
        int pick;
        logic [7:0] cb;
        pick = $urandom_range(0, 19);
        if (pick < 10)
            cb = CMD_DIGIT_0 + 8'($urandom_range(0, 9));
        else if (pick < 12)
            cb = CMD_FULL;
        else if (pick < 13)
            cb = CMD_STOP;
        else if (pick < 15)
            cb = CMD_DIR;
        else
            cb = 8'($urandom_range(0, 255));
        return {1'($urandom_range(0, 2) == 0), cb};
    endfunction

    // mostly clean motion in runs, some double jumps and random levels
    task automatic queue_random_word();
        logic [1:0] ab;
        logic [8:0] cmd;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            motion_fwd = !motion_fwd;
        if (pick < 82)
            ab = step_ab(stim_ab, motion_fwd);
        else if (pick < 92)
            ab = stim_ab ^ 2'b11;
        else
            ab = 2'($urandom_range(0, 3));
        cmd = random_command();
        queue_word(ab, cmd[8], cmd[7:0]);
    endtask

    task automatic settle();
        while (checked_count != queued_count)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == CFG_REPORT_INTERVAL)
            report_interval = data;
        else if (idx == CFG_RPM_SCALE)
            rpm_scale = data[15:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic new_phase(input logic [31:0] interval, input logic [15:0] scale);
        settle();
        tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
        rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
        write_reg(CFG_REPORT_INTERVAL, interval);
        write_reg(CFG_RPM_SCALE, {16'd0, scale});
    endtask

    always @(posedge i_clk) begin : word_driver
        int unsigned  gap;
        sample_word_t w;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            tx_wait     <= 0;
        end else if (!(in_if.valid && !in_if.ready)) begin
            gap = tx_wait;
            if (in_if.valid) begin
                expected_results.push_back(motor_step({in_if.enc_a, in_if.enc_b,
                                                       in_if.cmd_valid, in_if.cmd_byte}));
                gap = $urandom_range(0, tx_gap_max);
            end
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                tx_wait     <= gap - 1;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                in_if.enc_a     <= w.a;
                in_if.enc_b     <= w.b;
                in_if.cmd_valid <= w.cv;
                in_if.cmd_byte  <= w.cb;
                in_if.valid     <= 1'b1;
                tx_wait         <= 0;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        motor_result_t seen;
        motor_result_t want;
        int unsigned   gap;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            rx_wait      <= 0;
        end else if (out_if.valid && out_if.ready) begin
            seen = {out_if.drive_fwd_line, out_if.drive_rev_line, out_if.report_valid,
                    out_if.report_time, out_if.report_duty, out_if.report_position,
                    out_if.report_rpm_centi};
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result word with none expected: %s", show_result(seen));
            end else begin
                want = expected_results.pop_front();
                checked_count++;
                if (seen !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("result word %0d mismatch", checked_count);
                        $display("  expected %s", show_result(want));
                        $display("  actual   %s", show_result(seen));
                    end
                end
            end
            gap = $urandom_range(0, rx_gap_max);
            rx_wait      <= gap;
            out_if.ready <= (gap == 0);
        end else if (!out_if.ready) begin
            if (rx_wait <= 1) begin
                out_if.ready <= 1'b1;
                rx_wait      <= 0;
            end else begin
                rx_wait <= rx_wait - 1;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        in_if.valid     = 1'b0;
        in_if.enc_a     = 1'b0;
        in_if.enc_b     = 1'b0;
        in_if.cmd_valid = 1'b0;
        in_if.cmd_byte  = '0;
        out_if.ready    = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: register defaults, every transition, every command
        for (int i = 0; i < 10; i++)
            queue_word(DIRECTED_AB[39-2*i -: 2], 1'b1, CMD_DIGIT_0 + 8'(i));
        queue_word(DIRECTED_AB[19:18], 1'b1, CMD_FULL);
        queue_word(DIRECTED_AB[17:16], 1'b0, CMD_STOP);
        queue_word(DIRECTED_AB[15:14], 1'b1, 8'hFF);
        queue_word(DIRECTED_AB[13:12], 1'b1, CMD_DIR);
        queue_word(DIRECTED_AB[11:10], 1'b1, CMD_FULL);
        queue_word(DIRECTED_AB[9:8], 1'b1, CMD_DIGIT_0 + 8'd7);
        queue_word(DIRECTED_AB[7:6], 1'b1, 8'h00);
        queue_word(DIRECTED_AB[5:4], 1'b1, CMD_STOP);
        queue_word(DIRECTED_AB[3:2], 1'b1, CMD_DIR);
        queue_word(DIRECTED_AB[1:0], 1'b1, CMD_DIGIT_0 + 8'd3);

        // report on every word at the largest scale
        new_phase(32'd0, 16'hFFFF);
        repeat (5)
            queue_word(step_ab(stim_ab, 1'b1), 1'b0, 8'h00);

        for (int p = 0; p < 7; p++) begin
            case (p)
                0: new_phase(32'd1, RPM_SCALE_RST);
                1: new_phase(32'd0, 16'd1);
                2: new_phase(32'd7, 16'd1000);
                3: new_phase(32'hFFFF_FFFF, 16'd0);
                4: new_phase(32'd13, 16'hFFFF);
                5: new_phase(32'($urandom_range(2, 50)), 16'($urandom_range(0, 65535)));
                // interval 1 leaves the report window starting at the last word
                default: new_phase(32'd1, 16'($urandom_range(0, 65535)));
            endcase
            repeat (PHASE_WORDS) queue_random_word();
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
